/* hw/rtl/dttf_pkg.sv */
// shared constants for the decimal text to fixed point converter
`timescale 1ns / 1ps
`default_nettype none

package dttf_pkg;

  // widths of the stream fields
  localparam int unsigned CH_W    = 8;
  localparam int unsigned VALUE_W = 32;

  // default format: Q15.16 magnitude with a separate sign
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned INT_BITS_DEF  = 15;

  // fraction position counter
  localparam int unsigned          FPOS_W    = 3;
  localparam logic [FPOS_W-1:0]    FPOS_NONE = 3'd0;
  localparam logic [FPOS_W-1:0]    FPOS_ONE  = 3'd1;
  localparam logic [FPOS_W-1:0]    FPOS_TWO  = 3'd2;
  localparam logic [FPOS_W-1:0]    FPOS_THR  = 3'd3;
  localparam logic [FPOS_W-1:0]    FPOS_FOUR = 3'd4;
  localparam logic [FPOS_W-1:0]    FPOS_FIVE = 3'd5;
  localparam logic [FPOS_W-1:0]    FPOS_MAX  = 3'd7;

  // character codes
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

endpackage

`default_nettype wire

/* hw/rtl/decimal_text_to_fixed_core.sv */
// ascii decimal text to signed fixed point converter, one character per item
// a terminating character is held in the input register, then its result is registered in the output register
// throughput: one character per cycle unless a terminator waits for the output register, set by the digit update
//   (multiply by ten and add, or weighted fraction add) on the number state
// the input register keeps taking items while a result waits in the output register,
//   until a terminator reaches it; that terminator holds until the output register frees
// reset: asynchronous, active low; clears the number state, integer_only and all valids
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_fixed_core #(
  parameter int unsigned FRAC_BITS = dttf_pkg::FRAC_BITS_DEF,
  parameter int unsigned INT_BITS  = dttf_pkg::INT_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write channel: integer_only
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic                         cfg_data_i,
  // character stream in
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [dttf_pkg::CH_W-1:0]    s_axis_tdata,   // [7:0] ch
  // result stream out
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [dttf_pkg::VALUE_W-1:0] m_axis_tdata,   // [31:0] value
  output      logic                         m_axis_tuser    // [0] overflow
);
  import dttf_pkg::*;

  localparam int unsigned MAG_W  = INT_BITS + FRAC_BITS;
  localparam int unsigned PROD_W = FRAC_BITS + 4;
  localparam int unsigned VAL_W  = (MAG_W > VALUE_W) ? MAG_W : VALUE_W;

  // fraction weights round(2^FRAC_BITS / 10^k), worked out at elaboration
  localparam logic [63:0] ONE_F = 64'd1 << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] W1 = FRAC_BITS'((ONE_F + 64'd5) / 64'd10);
  localparam logic [FRAC_BITS-1:0] W2 = FRAC_BITS'((ONE_F + 64'd50) / 64'd100);
  localparam logic [FRAC_BITS-1:0] W3 = FRAC_BITS'((ONE_F + 64'd500) / 64'd1000);
  localparam logic [FRAC_BITS-1:0] W4 = FRAC_BITS'((ONE_F + 64'd5000) / 64'd10000);
  localparam logic [FRAC_BITS-1:0] W5 = FRAC_BITS'((ONE_F + 64'd50000) / 64'd100000);

  // configuration register, always ready
  logic integer_only_q;

  // input register
  logic            in_valid_q;
  logic [CH_W-1:0] ch_q;

  // number state
  logic [MAG_W-1:0]  mag_q,  mag_d;
  logic [FPOS_W-1:0] fpos_q, fpos_d;
  logic              neg_q,  neg_d;
  logic              sat_q,  sat_d;

  // output register
  logic               out_valid_q;
  logic [VALUE_W-1:0] value_q;
  logic               ovf_q;

  // character decode
  logic            is_digit, is_dot, is_minus, is_term;
  logic [3:0]      digit;
  logic            advance;

  // integer digit path
  logic [INT_BITS-1:0]   ip_cur;
  logic [INT_BITS+3:0]   ip_next;
  logic                  ip_over;

  // fraction digit path
  logic [FRAC_BITS-1:0]  weight;
  logic [PROD_W-1:0]     frac_add;
  logic [MAG_W:0]        frac_sum;

  // result value
  logic [VAL_W-1:0]      mag_ext, val_ext;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    digit    = 4'(ch_q - CH_ZERO);
    is_digit = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
    is_dot   = (ch_q == CH_DOT) && !integer_only_q;
    is_minus = (ch_q == CH_MINUS);
    is_term  = !is_digit && !is_dot && !is_minus;
  end

  // a terminator only moves on when the output register is free
  assign advance       = in_valid_q && (!is_term || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // integer part: times ten by shift-add, saturating at 2^INT_BITS - 1
  always_comb begin
    ip_cur  = mag_q[MAG_W-1:FRAC_BITS];
    ip_next = ({4'd0, ip_cur} << 3) + ({4'd0, ip_cur} << 1) + (INT_BITS+4)'(digit);
    ip_over = |ip_next[INT_BITS+3:INT_BITS];
  end

  // fraction part: digit times the weight of its position
  always_comb begin
    case (fpos_q)
      FPOS_ONE:  weight = W1;
      FPOS_TWO:  weight = W2;
      FPOS_THR:  weight = W3;
      FPOS_FOUR: weight = W4;
      FPOS_FIVE: weight = W5;
      default:   weight = '0;
    endcase
    frac_add = PROD_W'(digit) * PROD_W'(weight);
    frac_sum = {1'b0, mag_q} + (MAG_W+1)'(frac_add);
  end

  // next number state
  always_comb begin
    mag_d  = mag_q;
    fpos_d = fpos_q;
    neg_d  = neg_q;
    sat_d  = sat_q;
    if (is_digit) begin
      if (fpos_q == FPOS_NONE) begin
        if (ip_over) begin
          mag_d = {{INT_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
          sat_d = 1'b1;
        end else begin
          mag_d = {ip_next[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
        end
      end else begin
        // carry out of the top means the sum passed the largest magnitude
        if (frac_sum[MAG_W]) begin
          mag_d = '1;
          sat_d = 1'b1;
        end else begin
          mag_d = frac_sum[MAG_W-1:0];
        end
        if (fpos_q != FPOS_MAX) begin
          fpos_d = fpos_q + FPOS_ONE;
        end
      end
    end else if (is_dot) begin
      fpos_d = FPOS_ONE;
    end else if (is_minus) begin
      neg_d = 1'b1;
    end else begin
      mag_d  = '0;
      fpos_d = FPOS_NONE;
      neg_d  = 1'b0;
      sat_d  = 1'b0;
    end
  end

  // two's complement, low bits kept when the magnitude is wider than the port
  always_comb begin
    mag_ext = VAL_W'(mag_q);
    val_ext = neg_q ? (VAL_W'(0) - mag_ext) : mag_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integer_only_q <= 1'b0;
    end else if (cfg_valid_i) begin
      integer_only_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ch_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q  <= '0;
      fpos_q <= FPOS_NONE;
      neg_q  <= 1'b0;
      sat_q  <= 1'b0;
    end else if (advance) begin
      mag_q  <= mag_d;
      fpos_q <= fpos_d;
      neg_q  <= neg_d;
      sat_q  <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_term) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_term) begin
      value_q <= val_ext[VALUE_W-1:0];
      ovf_q   <= sat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = value_q;
  assign m_axis_tuser  = ovf_q;

endmodule

`default_nettype wire

/* hw/rtl/dttf_checker.sv */
// port-level checks for the decimal text to fixed point converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module dttf_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cfg_valid_i,
  input wire logic                         cfg_ready_o,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [dttf_pkg::VALUE_W-1:0] m_axis_tdata,
  input wire logic                         m_axis_tuser
);
  import dttf_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  // input back-pressure only comes from a stalled output
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // a fresh result needs an item taken into the input register ahead of it, or one held there since
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready, 2) || $past(!s_axis_tready, 2))
    else $error("result item without a terminating character");

  // the configuration channel never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind decimal_text_to_fixed_core dttf_checker u_dttf_checker (.*);

`default_nettype wire
